// ----- rtl/core/pmfb_pkg.sv -----
// Paged mono framebuffer: shared types, codes and constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pmfb_pkg;

    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam int PAGE_W = 4;
    localparam int SUM_W  = 12;

    localparam logic [7:0] WIDTH_RST  = 8'd128;
    localparam logic [6:0] HEIGHT_RST = 7'd64;
    localparam logic [7:0] STRIDE_RST = 8'd0;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_STRIDE = 2'd2;

    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [7:0] BYTE_ONES = 8'hFF;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    typedef enum logic [1:0] {
        REQ_SET  = 2'd0,
        REQ_GET  = 2'd1,
        REQ_FILL = 2'd2,
        REQ_RECT = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ROW,
        ST_REDUCE,
        ST_READ,
        ST_MODIFY,
        ST_FILL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic row_start;
        logic load_addr;
        logic mem_read;
        logic modify;
        logic fill_write;
        logic advance;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_pixel;
        logic is_fill;
        logic skip;
        logic last_col;
        logic last_page;
        logic red_done;
        logic res_full;
    } ctrl_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/pmfb_modred.sv -----
// Paged mono framebuffer: iterative reduction of a byte address modulo the memory depth.
// One restoring compare-and-subtract step per cycle; depends on pmfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmfb_modred #(
    parameter int DIVISOR = 1024
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [pmfb_pkg::SUM_W-1:0] value,
    output logic                            busy,
    output logic      [pmfb_pkg::SUM_W-1:0] result
);

    localparam int VW    = pmfb_pkg::SUM_W;
    localparam int DL    = $clog2(DIVISOR + 1) - 1;
    localparam int NSTEP = (VW > DL) ? (VW - DL) : 0;
    localparam int CW    = (NSTEP > 0) ? $clog2(NSTEP + 1) : 1;

    logic [VW-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [VW:0]   dk;

    always_comb begin
        dk        = (VW + 1)'(DIVISOR) << (cnt_reg - CW'(1));
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = value;
            cnt_next  = CW'(NSTEP);
            busy_next = (NSTEP != 0);
        end else if (busy_reg) begin
            if ({1'b0, rem_reg} >= dk) begin
                rem_next = rem_reg - dk[VW-1:0];
            end
            cnt_next  = cnt_reg - CW'(1);
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
    end

    assign busy   = busy_reg;
    assign result = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pmfb_datapath.sv -----
// Paged mono framebuffer datapath: registers, command latch, walk counters, frame memory,
// result register. Depends on pmfb_pkg and pmfb_modred.
`timescale 1ns / 1ps
`default_nettype none

module pmfb_datapath #(
    parameter int MAX_WIDTH  = pmfb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = pmfb_pkg::MAX_HEIGHT_DEF,
    parameter int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT / 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [7:0]             cfg_wdata,
    input  wire logic [31:0]            s_tdata,
    input  wire logic [1:0]             s_tuser,
    input  wire logic                   m_tready,
    output logic                        m_tvalid,
    output logic      [7:0]             m_tdata,
    input  wire pmfb_pkg::ctrl_cmd_t    cmd,
    output pmfb_pkg::ctrl_status_t      status
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int PW = pmfb_pkg::PAGE_W;
    localparam int VW = pmfb_pkg::SUM_W;
    localparam logic [8:0]    WMAX      = 9'(MAX_WIDTH);
    localparam logic [7:0]    HMAX      = 8'(MAX_HEIGHT);
    localparam logic [AW-1:0] ADDR_LAST = AW'(MEM_DEPTH - 1);

    logic [7:0] width_reg, stride_reg;
    logic [6:0] height_reg;

    pmfb_pkg::req_t req_reg;
    logic [7:0]     x0_reg, x1_reg;
    logic [6:0]     y0_reg, y1_reg;
    logic           color_reg;

    logic [7:0]    col_reg;
    logic [PW-1:0] page_reg;
    logic [AW-1:0] addr_reg;
    logic [7:0]    rd_reg;
    logic          pix_reg;
    logic          res_valid_reg, res_pix_reg, res_oor_reg;

    logic [7:0] mem [MEM_DEPTH];

    logic [7:0]    w_eff, s_eff, xfirst, xlast, pmask, rmask, mask, mod_byte, fill_byte;
    logic [6:0]    h_cap, h_eff, y1m1;
    logic [PW-1:0] pages, plast;
    logic [2:0]    lo, hm1;
    logic          is_pixel, is_get, is_fill, is_rect;
    logic          pix_oor, rect_oor, rect_empty, fill_empty, oor, last_col;
    logic [VW-1:0] red_value, red_result;
    logic          red_busy;

    pmfb_pkg::req_t req_in;

    always_comb begin
        w_eff  = ({1'b0, width_reg} < WMAX) ? width_reg : WMAX[7:0];
        h_cap  = ({1'b0, height_reg} < HMAX) ? height_reg : HMAX[6:0];
        h_eff  = {h_cap[6:3], 3'b000};
        pages  = h_cap[6:3];
        s_eff  = (stride_reg == 8'd0) ? w_eff : stride_reg;

        is_get   = (req_reg == pmfb_pkg::REQ_GET);
        is_pixel = (req_reg == pmfb_pkg::REQ_SET) || is_get;
        is_fill  = (req_reg == pmfb_pkg::REQ_FILL);
        is_rect  = (req_reg == pmfb_pkg::REQ_RECT);

        pix_oor    = (x0_reg >= w_eff) || (y0_reg >= h_eff);
        rect_oor   = (x0_reg > w_eff) || (x1_reg > w_eff) ||
                     (y0_reg > h_eff) || (y1_reg > h_eff);
        rect_empty = (x0_reg >= x1_reg) || (y0_reg >= y1_reg);
        fill_empty = (pages == '0) || (w_eff == 8'd0);
        oor        = is_pixel ? pix_oor : (is_rect ? rect_oor : 1'b0);

        y1m1   = y1_reg - 7'd1;
        xfirst = is_fill ? 8'd0 : x0_reg;
        xlast  = is_fill ? (w_eff - 8'd1) : (x1_reg - 8'd1);
        plast  = is_fill ? (pages - PW'(1)) : y1m1[6:3];
        last_col = (col_reg == xlast);

        lo    = (page_reg == y0_reg[6:3]) ? y0_reg[2:0] : 3'd0;
        hm1   = (page_reg == plast) ? y1m1[2:0] : 3'd7;
        rmask = (pmfb_pkg::BYTE_ONES << lo) & (pmfb_pkg::BYTE_ONES >> (3'd7 - hm1));
        pmask = pmfb_pkg::BYTE_ONE << y0_reg[2:0];
        mask  = is_pixel ? pmask : rmask;

        mod_byte  = color_reg ? (rd_reg | mask) : (rd_reg & ~mask);
        fill_byte = color_reg ? pmfb_pkg::BYTE_ONES : pmfb_pkg::BYTE_ZERO;

        red_value = VW'(page_reg) * VW'(s_eff) + VW'(col_reg);
        req_in    = pmfb_pkg::req_t'(s_tuser);
    end

    pmfb_modred #(
        .DIVISOR (MEM_DEPTH)
    ) u_modred (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.row_start),
        .value   (red_value),
        .busy    (red_busy),
        .result  (red_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= pmfb_pkg::WIDTH_RST;
            height_reg <= pmfb_pkg::HEIGHT_RST;
            stride_reg <= pmfb_pkg::STRIDE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pmfb_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata;
                pmfb_pkg::CFG_HEIGHT: height_reg <= cfg_wdata[6:0];
                pmfb_pkg::CFG_STRIDE: stride_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg   <= req_in;
            x0_reg    <= s_tdata[7:0];
            y0_reg    <= s_tdata[14:8];
            x1_reg    <= s_tdata[22:15];
            y1_reg    <= s_tdata[29:23];
            color_reg <= s_tdata[30];
            col_reg   <= (req_in == pmfb_pkg::REQ_FILL) ? 8'd0 : s_tdata[7:0];
            page_reg  <= (req_in == pmfb_pkg::REQ_FILL) ? PW'(0) : s_tdata[14:11];
        end else if (cmd.advance) begin
            if (last_col) begin
                col_reg  <= xfirst;
                page_reg <= page_reg + PW'(1);
            end else begin
                col_reg  <= col_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_addr) begin
            addr_reg <= AW'(red_result);
        end else if (cmd.advance && !last_col) begin
            addr_reg <= (addr_reg == ADDR_LAST) ? '0 : addr_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fill_write) begin
            mem[addr_reg] <= fill_byte;
        end else if (cmd.modify && !is_get) begin
            mem[addr_reg] <= mod_byte;
        end
        if (cmd.mem_read) begin
            rd_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pix_reg <= 1'b0;
        end else if (cmd.modify && is_get) begin
            pix_reg <= rd_reg[y0_reg[2:0]];
        end
        if (cmd.finish) begin
            res_pix_reg <= pix_reg;
            res_oor_reg <= oor;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            res_valid_reg <= 1'b1;
        end else if (m_tready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_comb begin
        status.is_pixel  = is_pixel;
        status.is_fill   = is_fill;
        status.skip      = is_pixel ? pix_oor :
                           (is_fill ? fill_empty : (rect_oor || rect_empty));
        status.last_col  = last_col;
        status.last_page = (page_reg == plast);
        status.red_done  = !red_busy;
        status.res_full  = res_valid_reg;
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {6'b000000, res_oor_reg, res_pix_reg};

endmodule

`default_nettype wire

// ----- rtl/core/pmfb_ctrl.sv -----
// Paged mono framebuffer controller: sequences checks, address reduction, read-modify-write
// and fill walks. Depends on pmfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmfb_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire pmfb_pkg::ctrl_status_t status,
    output pmfb_pkg::ctrl_cmd_t         cmd
);

    pmfb_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pmfb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pmfb_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = pmfb_pkg::ST_CHECK;
            end
            pmfb_pkg::ST_CHECK: begin
                state_next = status.skip ? pmfb_pkg::ST_DONE : pmfb_pkg::ST_ROW;
            end
            pmfb_pkg::ST_ROW: begin
                state_next = pmfb_pkg::ST_REDUCE;
            end
            pmfb_pkg::ST_REDUCE: begin
                if (status.red_done) begin
                    state_next = status.is_fill ? pmfb_pkg::ST_FILL : pmfb_pkg::ST_READ;
                end
            end
            pmfb_pkg::ST_READ: begin
                state_next = pmfb_pkg::ST_MODIFY;
            end
            pmfb_pkg::ST_MODIFY: begin
                if (status.is_pixel || (status.last_col && status.last_page)) begin
                    state_next = pmfb_pkg::ST_DONE;
                end else if (status.last_col) begin
                    state_next = pmfb_pkg::ST_ROW;
                end else begin
                    state_next = pmfb_pkg::ST_READ;
                end
            end
            pmfb_pkg::ST_FILL: begin
                if (status.last_col && status.last_page) begin
                    state_next = pmfb_pkg::ST_DONE;
                end else if (status.last_col) begin
                    state_next = pmfb_pkg::ST_ROW;
                end
            end
            pmfb_pkg::ST_DONE: begin
                if (!status.res_full) state_next = pmfb_pkg::ST_IDLE;
            end
            default: state_next = pmfb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready       = (state_reg == pmfb_pkg::ST_IDLE);
        cmd.accept     = (state_reg == pmfb_pkg::ST_IDLE) && s_tvalid;
        cmd.row_start  = (state_reg == pmfb_pkg::ST_ROW);
        cmd.load_addr  = (state_reg == pmfb_pkg::ST_REDUCE) && status.red_done;
        cmd.mem_read   = (state_reg == pmfb_pkg::ST_READ);
        cmd.modify     = (state_reg == pmfb_pkg::ST_MODIFY);
        cmd.fill_write = (state_reg == pmfb_pkg::ST_FILL);
        cmd.advance    = ((state_reg == pmfb_pkg::ST_MODIFY) && !status.is_pixel) ||
                         (state_reg == pmfb_pkg::ST_FILL);
        cmd.finish     = (state_reg == pmfb_pkg::ST_DONE) && !status.res_full;
    end

endmodule

`default_nettype wire

// ----- rtl/core/paged_mono_framebuffer.sv -----
// Paged mono framebuffer top level: ties the controller to the datapath.
// Depends on pmfb_pkg, pmfb_ctrl and pmfb_datapath.
//
// Usage:
//   Input words (s_) carry one command: set pixel, get pixel, fill frame or fill
//   rectangle. Each command returns exactly one result word (m_) with the pixel
//   read by a get and the out-of-range flag. Registers width, height and
//   row_stride are written through cfg_we/cfg_index/cfg_wdata; the user must
//   write them only while idle, as the block does not enforce it. One command
//   is worked at a time; s_tready is high only while idle.
//   The address unit reduces each address in R = SUM_W - floor(log2(MEM_DEPTH))
//   reduction steps, 2 at the default size. An out-of-range or empty command goes
//   from its check straight to the result. A set or get pixel reduces the address,
//   then reads and modifies one byte. A fill frame reduces the address once per
//   page, then writes each byte of the page row; a fill rectangle instead reads
//   and modifies each byte. The single-port frame memory allows one
//   read-modify-write per byte, and the address reduction runs once per page.
//   Reset returns the registers to 128 x 64 with stride equal to width and
//   leaves the frame memory undefined until written. When m_tready is low the
//   result holds in its register; the next command is taken meanwhile and
//   waits at its end until the register drains.
`timescale 1ns / 1ps
`default_nettype none

module paged_mono_framebuffer #(
    parameter int MAX_WIDTH  = pmfb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = pmfb_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // x_start[7:0], y_start[14:8], x_end[22:15], y_end[29:23], color[30], zero[31]
    input  wire logic [31:0] s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pixel[0], out_of_range[1], zero[7:2]
    output logic      [7:0]  m_tdata
);

    localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT / 8;

    pmfb_pkg::ctrl_cmd_t    cmd;
    pmfb_pkg::ctrl_status_t status;

    pmfb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pmfb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MEM_DEPTH  (MEM_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire
